>>> design/rtsp_pkg.sv
// Package for the relocation table stream parser.
// Holds the parse phase type, the result and configuration structs, and constants.
// No dependencies.
package rtsp_pkg;

  typedef enum logic [2:0] {
    PH_DELTA  = 3'd0,
    PH_TYPE   = 3'd1,
    PH_SEG    = 3'd2,
    PH_UND_LO = 3'd3,
    PH_UND_HI = 3'd4,
    PH_LAY_LO = 3'd5,
    PH_LAY_HI = 3'd6,
    PH_AUX    = 3'd7
  } phase_t;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_UNDEF_SEG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUX       = 2'd2;

  localparam logic [7:0]  DELTA_END   = 8'd0;
  localparam logic [7:0]  DELTA_SKIP  = 8'd255;
  localparam logic [31:0] SKIP_ADD    = 32'd254;
  localparam logic [31:0] OFFSET_INIT = 32'hFFFF_FFFF;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_END    = 1'b1;

  typedef struct packed {
    logic [7:0] undefined_segment_id;
    logic [7:0] layout_type_mask;
    logic [7:0] aux_type_mask;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] reloc_offset;
    logic [7:0]  reloc_type;
    logic [7:0]  segment_id;
    logic [15:0] undefined_index;
    logic [15:0] layout_idx;
    logic        has_layout;
    logic [7:0]  aux_low;
    logic        has_aux;
  } result_t;

endpackage

>>> design/rtsp_in_stage.sv
// Input register of the relocation table stream parser.
// Holds one accepted byte until the parser consumes it. Uses rtsp_pkg.
module rtsp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_stream_byte,
  input  logic       consume,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || consume;
  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (consume) begin
      valid_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_stream_byte;
    end
  end

endmodule

>>> design/rtsp_parser.sv
// Parse state of the relocation table stream parser: phase, running offset, held fields.
// Decides per byte whether a result is produced and forms it. Uses rtsp_pkg.
module rtsp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       byte_data,
  input  logic             step,
  input  rtsp_pkg::cfg_t   cfg,
  output logic             emit,
  output rtsp_pkg::result_t result
);

  rtsp_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  seg_r, seg_nxt;
  logic [15:0] und_r, und_nxt;
  logic [15:0] lay_r, lay_nxt;
  logic [7:0]  aux_r, aux_nxt;
  logic        want_lay_r, want_lay_nxt;
  logic        want_aux_r, want_aux_nxt;
  logic        emit_end;
  logic        emit_rec;

  always_comb begin
    phase_nxt    = phase_r;
    offset_nxt   = offset_r;
    type_nxt     = type_r;
    seg_nxt      = seg_r;
    und_nxt      = und_r;
    lay_nxt      = lay_r;
    aux_nxt      = aux_r;
    want_lay_nxt = want_lay_r;
    want_aux_nxt = want_aux_r;
    emit_end     = 1'b0;
    emit_rec     = 1'b0;
    unique case (phase_r)
      rtsp_pkg::PH_DELTA: begin
        if (byte_data == rtsp_pkg::DELTA_END) begin
          emit_end   = 1'b1;
          offset_nxt = rtsp_pkg::OFFSET_INIT;
        end else if (byte_data == rtsp_pkg::DELTA_SKIP) begin
          offset_nxt = offset_r + rtsp_pkg::SKIP_ADD;
        end else begin
          offset_nxt   = offset_r + {24'd0, byte_data};
          type_nxt     = 8'd0;
          seg_nxt      = 8'd0;
          und_nxt      = 16'd0;
          lay_nxt      = 16'd0;
          aux_nxt      = 8'd0;
          want_lay_nxt = 1'b0;
          want_aux_nxt = 1'b0;
          phase_nxt    = rtsp_pkg::PH_TYPE;
        end
      end
      rtsp_pkg::PH_TYPE: begin
        type_nxt  = byte_data;
        phase_nxt = rtsp_pkg::PH_SEG;
      end
      rtsp_pkg::PH_SEG: begin
        seg_nxt      = byte_data;
        want_lay_nxt = |(type_r & cfg.layout_type_mask);
        want_aux_nxt = |(type_r & cfg.aux_type_mask);
        if (byte_data == cfg.undefined_segment_id) begin
          phase_nxt = rtsp_pkg::PH_UND_LO;
        end else if (want_lay_nxt) begin
          phase_nxt = rtsp_pkg::PH_LAY_LO;
        end else if (want_aux_nxt) begin
          phase_nxt = rtsp_pkg::PH_AUX;
        end else begin
          emit_rec  = 1'b1;
          phase_nxt = rtsp_pkg::PH_DELTA;
        end
      end
      rtsp_pkg::PH_UND_LO: begin
        und_nxt   = {8'd0, byte_data};
        phase_nxt = rtsp_pkg::PH_UND_HI;
      end
      rtsp_pkg::PH_UND_HI: begin
        und_nxt = {byte_data, und_r[7:0]};
        if (want_lay_r) begin
          phase_nxt = rtsp_pkg::PH_LAY_LO;
        end else if (want_aux_r) begin
          phase_nxt = rtsp_pkg::PH_AUX;
        end else begin
          emit_rec  = 1'b1;
          phase_nxt = rtsp_pkg::PH_DELTA;
        end
      end
      rtsp_pkg::PH_LAY_LO: begin
        lay_nxt   = {8'd0, byte_data};
        phase_nxt = rtsp_pkg::PH_LAY_HI;
      end
      rtsp_pkg::PH_LAY_HI: begin
        lay_nxt = {byte_data, lay_r[7:0]};
        if (want_aux_r) begin
          phase_nxt = rtsp_pkg::PH_AUX;
        end else begin
          emit_rec  = 1'b1;
          phase_nxt = rtsp_pkg::PH_DELTA;
        end
      end
      rtsp_pkg::PH_AUX: begin
        aux_nxt   = byte_data;
        emit_rec  = 1'b1;
        phase_nxt = rtsp_pkg::PH_DELTA;
      end
    endcase
  end

  assign emit = emit_end || emit_rec;

  always_comb begin
    result = '0;
    if (emit_end) begin
      result.kind = rtsp_pkg::KIND_END;
    end else begin
      result.kind            = rtsp_pkg::KIND_RECORD;
      result.reloc_offset    = offset_nxt;
      result.reloc_type      = type_nxt;
      result.segment_id      = seg_nxt;
      result.undefined_index = und_nxt;
      result.layout_idx      = lay_nxt;
      result.has_layout      = want_lay_nxt;
      result.aux_low         = aux_nxt;
      result.has_aux         = want_aux_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= rtsp_pkg::PH_DELTA;
      offset_r   <= rtsp_pkg::OFFSET_INIT;
      want_lay_r <= 1'b0;
      want_aux_r <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      offset_r   <= offset_nxt;
      want_lay_r <= want_lay_nxt;
      want_aux_r <= want_aux_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      type_r <= type_nxt;
      seg_r  <= seg_nxt;
      und_r  <= und_nxt;
      lay_r  <= lay_nxt;
      aux_r  <= aux_nxt;
    end
  end

endmodule

>>> design/rtsp_out_reg.sv
// Result register of the relocation table stream parser.
// Holds one result item until the consumer takes it. Uses rtsp_pkg.
module rtsp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rtsp_pkg::result_t push_data,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_ready,
  output rtsp_pkg::result_t out_data
);

  logic              valid_r;
  logic              valid_nxt;
  rtsp_pkg::result_t data_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) begin
      valid_nxt = 1'b0;
    end
    if (push) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

endmodule

>>> design/relocation_table_stream_parser_top.sv
// Top level of the relocation table stream parser.
// Instantiates rtsp_in_stage, rtsp_parser and rtsp_out_reg; holds the config registers.
// Uses rtsp_pkg.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_stream_byte
//   out_     output     out_valid / out_ready  out_kind .. out_has_aux
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte per cycle sustained while no held result stalls the parser; a result is formed
// by the parser from the byte in the input register and is registered in the result register.
// Synchronous active-low reset clears the valid flags, phase and running offset (all ones).
// A held result with out_ready low stalls the parser only on a byte that makes a result.
// Config writes never wait; cfg_ready is always high.
module relocation_table_stream_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [31:0] out_reloc_offset,
  output logic [7:0]  out_reloc_type,
  output logic [7:0]  out_segment_id,
  output logic [15:0] out_undefined_index,
  output logic [15:0] out_layout_idx,
  output logic        out_has_layout,
  output logic [7:0]  out_aux_low,
  output logic        out_has_aux,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  rtsp_pkg::cfg_t    cfg_r;
  rtsp_pkg::result_t result;
  rtsp_pkg::result_t out_data;
  logic              byte_valid;
  logic [7:0]        byte_data;
  logic              emit;
  logic              slot_free;
  logic              step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        rtsp_pkg::CFG_UNDEF_SEG: cfg_r.undefined_segment_id <= cfg_data;
        rtsp_pkg::CFG_LAYOUT:    cfg_r.layout_type_mask     <= cfg_data;
        rtsp_pkg::CFG_AUX:       cfg_r.aux_type_mask        <= cfg_data;
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  assign step = byte_valid && (!emit || slot_free);

  rtsp_in_stage u_in (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_stream_byte (in_stream_byte),
    .consume        (step),
    .byte_valid     (byte_valid),
    .byte_data      (byte_data)
  );

  rtsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_data (byte_data),
    .step      (step),
    .cfg       (cfg_r),
    .emit      (emit),
    .result    (result)
  );

  rtsp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step && emit),
    .push_data (result),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_kind            = out_data.kind;
  assign out_reloc_offset    = out_data.reloc_offset;
  assign out_reloc_type      = out_data.reloc_type;
  assign out_segment_id      = out_data.segment_id;
  assign out_undefined_index = out_data.undefined_index;
  assign out_layout_idx      = out_data.layout_idx;
  assign out_has_layout      = out_data.has_layout;
  assign out_aux_low         = out_data.aux_low;
  assign out_has_aux         = out_data.has_aux;

endmodule

>>> design/rtsp_checker.sv
// Port-level checks for the relocation table stream parser.
// Bound to relocation_table_stream_parser_top; sees its ports only.
module rtsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_stream_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [31:0] out_reloc_offset,
  input logic [7:0]  out_reloc_type,
  input logic [7:0]  out_segment_id,
  input logic [15:0] out_undefined_index,
  input logic [15:0] out_layout_idx,
  input logic        out_has_layout,
  input logic [7:0]  out_aux_low,
  input logic        out_has_aux,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [7:0]  cfg_data
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind)
      && $stable(out_reloc_offset) && $stable(out_segment_id))
    else $error("stalled result item changed");

  a_end_all_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_reloc_offset == 32'd0 && out_reloc_type == 8'd0
      && out_segment_id == 8'd0 && !out_has_layout && !out_has_aux)
    else $error("end-of-table item carries record fields");

  a_layout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_layout |-> out_layout_idx == 16'd0)
    else $error("layout index set without layout flag");

  a_aux_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_aux |-> out_aux_low == 8'd0)
    else $error("aux byte set without aux flag");

endmodule

bind relocation_table_stream_parser_top rtsp_checker u_rtsp_checker (.*);

>>> verif/rtsp_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the relocation table stream parser testbench: follows the byte and
// register channels, predicts every record and table end, and compares them with out_.
// Depends on rtsp_pkg.
module rtsp_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_kind,
  input  logic [31:0] out_reloc_offset,
  input  logic [7:0]  out_reloc_type,
  input  logic [7:0]  out_segment_id,
  input  logic [15:0] out_undefined_index,
  input  logic [15:0] out_layout_idx,
  input  logic        out_has_layout,
  input  logic [7:0]  out_aux_low,
  input  logic        out_has_aux,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          outstanding,
  output int          records_checked,
  output int          ends_checked
);

  localparam int MAX_REPORTS = 10;

  rtsp_pkg::cfg_t    regs;
  rtsp_pkg::phase_t  parse_phase;
  logic [31:0]       offset_sum;
  logic [7:0]        rec_type;
  logic [7:0]        rec_segment;
  logic [15:0]       rec_undef_idx;
  logic [15:0]       rec_layout_idx;
  logic [7:0]        rec_aux;
  logic              rec_has_layout;
  logic              rec_has_aux;
  rtsp_pkg::result_t pending_results[$];
  int                fault_total;
  int                record_total;
  int                end_total;

  function automatic string describe(input rtsp_pkg::result_t r);
    return $sformatf("kind %0d offset %h type %h seg %h undef %h layout %h/%0d aux %h/%0d",
                     r.kind, r.reloc_offset, r.reloc_type, r.segment_id, r.undefined_index,
                     r.layout_idx, r.has_layout, r.aux_low, r.has_aux);
  endfunction

  task automatic close_record();
    rtsp_pkg::result_t rec;
    rec.kind            = rtsp_pkg::KIND_RECORD;
    rec.reloc_offset    = offset_sum;
    rec.reloc_type      = rec_type;
    rec.segment_id      = rec_segment;
    rec.undefined_index = rec_undef_idx;
    rec.layout_idx      = rec_layout_idx;
    rec.has_layout      = rec_has_layout;
    rec.aux_low         = rec_aux;
    rec.has_aux         = rec_has_aux;
    pending_results.push_back(rec);
    parse_phase = rtsp_pkg::PH_DELTA;
  endtask

  task automatic after_index_fields();
    if (rec_has_layout) parse_phase = rtsp_pkg::PH_LAY_LO;
    else if (rec_has_aux) parse_phase = rtsp_pkg::PH_AUX;
    else close_record();
  endtask

  task automatic consume_byte(input logic [7:0] b);
    rtsp_pkg::result_t table_end;
    case (parse_phase)
      rtsp_pkg::PH_DELTA: begin
        if (b == rtsp_pkg::DELTA_END) begin
          table_end = '0;
          table_end.kind = rtsp_pkg::KIND_END;
          pending_results.push_back(table_end);
          offset_sum = rtsp_pkg::OFFSET_INIT;
        end else if (b == rtsp_pkg::DELTA_SKIP) begin
          offset_sum = offset_sum + rtsp_pkg::SKIP_ADD;
        end else begin
          offset_sum     = offset_sum + {24'd0, b};
          rec_type       = '0;
          rec_segment    = '0;
          rec_undef_idx  = '0;
          rec_layout_idx = '0;
          rec_aux        = '0;
          rec_has_layout = 1'b0;
          rec_has_aux    = 1'b0;
          parse_phase    = rtsp_pkg::PH_TYPE;
        end
      end
      rtsp_pkg::PH_TYPE: begin
        rec_type    = b;
        parse_phase = rtsp_pkg::PH_SEG;
      end
      rtsp_pkg::PH_SEG: begin
        rec_segment    = b;
        rec_has_layout = |(rec_type & regs.layout_type_mask);
        rec_has_aux    = |(rec_type & regs.aux_type_mask);
        if (b == regs.undefined_segment_id) parse_phase = rtsp_pkg::PH_UND_LO;
        else after_index_fields();
      end
      rtsp_pkg::PH_UND_LO: begin
        rec_undef_idx[7:0] = b;
        parse_phase        = rtsp_pkg::PH_UND_HI;
      end
      rtsp_pkg::PH_UND_HI: begin
        rec_undef_idx[15:8] = b;
        after_index_fields();
      end
      rtsp_pkg::PH_LAY_LO: begin
        rec_layout_idx[7:0] = b;
        parse_phase         = rtsp_pkg::PH_LAY_HI;
      end
      rtsp_pkg::PH_LAY_HI: begin
        rec_layout_idx[15:8] = b;
        if (rec_has_aux) parse_phase = rtsp_pkg::PH_AUX;
        else close_record();
      end
      rtsp_pkg::PH_AUX: begin
        rec_aux = b;
        close_record();
      end
      default: parse_phase = rtsp_pkg::PH_DELTA;
    endcase
  endtask

  task automatic check_result();
    rtsp_pkg::result_t got;
    rtsp_pkg::result_t want;
    got.kind            = out_kind;
    got.reloc_offset    = out_reloc_offset;
    got.reloc_type      = out_reloc_type;
    got.segment_id      = out_segment_id;
    got.undefined_index = out_undefined_index;
    got.layout_idx      = out_layout_idx;
    got.has_layout      = out_has_layout;
    got.aux_low         = out_aux_low;
    got.has_aux         = out_has_aux;
    if (pending_results.size() == 0) begin
      if (fault_total < MAX_REPORTS) $display("unexpected result: %s", describe(got));
      fault_total++;
    end else begin
      want = pending_results.pop_front();
      if (want.kind == rtsp_pkg::KIND_END) end_total++;
      else record_total++;
      if (got !== want) begin
        if (fault_total < MAX_REPORTS) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
        fault_total++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs           = '0;
      parse_phase    = rtsp_pkg::PH_DELTA;
      offset_sum     = rtsp_pkg::OFFSET_INIT;
      rec_type       = '0;
      rec_segment    = '0;
      rec_undef_idx  = '0;
      rec_layout_idx = '0;
      rec_aux        = '0;
      rec_has_layout = 1'b0;
      rec_has_aux    = 1'b0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rtsp_pkg::CFG_UNDEF_SEG: regs.undefined_segment_id = cfg_data;
          rtsp_pkg::CFG_LAYOUT:    regs.layout_type_mask     = cfg_data;
          rtsp_pkg::CFG_AUX:       regs.aux_type_mask        = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) consume_byte(in_stream_byte);
    end
    mismatches      <= fault_total;
    outstanding     <= pending_results.size();
    records_checked <= record_total;
    ends_checked    <= end_total;
  end

endmodule

>>> verif/relocation_table_stream_parser_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the relocation table stream parser: clock, reset, byte and register
// stimulus, result back-pressure, watchdog and verdict.
// Depends on rtsp_pkg, relocation_table_stream_parser_top and rtsp_result_checker.
module relocation_table_stream_parser_top_tb;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int MAX_IDLE          = 12;
  localparam int SETTLE_CYCLES     = 8;
  localparam int LONG_HOLD         = 300;
  localparam int WATCHDOG_LIMIT    = 4000;
  localparam int RANDOM_SETTINGS   = 6;
  localparam int ITEMS_PER_SETTING = 155;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_stream_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [31:0] out_reloc_offset;
  logic [7:0]  out_reloc_type;
  logic [7:0]  out_segment_id;
  logic [15:0] out_undefined_index;
  logic [15:0] out_layout_idx;
  logic        out_has_layout;
  logic [7:0]  out_aux_low;
  logic        out_has_aux;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'h00;

  int          mismatches;
  int          outstanding;
  int          records_checked;
  int          ends_checked;
  int          bytes_sent = 0;
  int          settings_applied = 1;
  int          idle_cycles = 0;
  int          holds_asked = 0;
  logic [7:0]  cur_undef = 8'h00;
  logic [7:0]  cur_layout = 8'h00;
  logic [7:0]  cur_aux = 8'h00;
  bit          sender_steady = 1'b0;

  relocation_table_stream_parser_top dut (.*);

  rtsp_result_checker result_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("no item accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("relocation_table_stream_parser_top_tb: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int draw_gap(input bit steady);
    return steady ? 0 : int'($urandom_range(0, MAX_IDLE));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap(sender_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_registers(input logic [7:0] undef_id, input logic [7:0] lay_mask,
                                   input logic [7:0] aux_mask);
    write_register(rtsp_pkg::CFG_UNDEF_SEG, undef_id);
    write_register(rtsp_pkg::CFG_LAYOUT, lay_mask);
    write_register(rtsp_pkg::CFG_AUX, aux_mask);
    write_register(CFG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
    cur_undef  = undef_id;
    cur_layout = lay_mask;
    cur_aux    = aux_mask;
    settings_applied++;
  endtask

  task automatic send_record();
    logic [7:0] rtype;
    logic [7:0] seg;
    int         tail;
    if ($urandom_range(0, 4) == 0) send_byte(rtsp_pkg::DELTA_SKIP);
    send_byte(8'($urandom_range(1, 254)));
    rtype = 8'($urandom_range(0, 255));
    seg   = ($urandom_range(0, 2) == 0) ? cur_undef : 8'($urandom_range(0, 255));
    send_byte(rtype);
    send_byte(seg);
    tail = ((seg == cur_undef) ? 2 : 0) + ((|(rtype & cur_layout)) ? 2 : 0)
         + ((|(rtype & cur_aux)) ? 1 : 0);
    repeat (tail) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_table();
    int n;
    n = $urandom_range(0, 6);
    sender_steady = ($urandom_range(0, 3) == 0);
    repeat (n) send_record();
    send_byte(rtsp_pkg::DELTA_END);
  endtask

  // garbage, then enough skip bytes to finish any open record, then a table end
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 10);
    sender_steady = 1'b0;
    repeat (n) send_byte(8'($urandom_range(0, 255)));
    repeat (8) send_byte(rtsp_pkg::DELTA_SKIP);
    send_byte(rtsp_pkg::DELTA_END);
  endtask

  initial begin
    int  stall;
    int  holds_done;
    bit  steady;
    holds_done = 0;
    steady     = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_done != holds_asked) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if ($urandom_range(0, 15) == 0) steady = !steady;
      stall = draw_gap(steady);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int phase_start;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(rtsp_pkg::DELTA_END);
    send_byte(rtsp_pkg::DELTA_SKIP);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hFE);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(rtsp_pkg::DELTA_END);
    settle();

    program_registers(8'hFF, 8'hFF, 8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h34);
    send_byte(8'h12);
    send_byte(8'h78);
    send_byte(8'h56);
    send_byte(8'hAB);
    // hold a record open past its segment byte, then clear the masks
    send_byte(8'h03);
    send_byte(8'h10);
    send_byte(8'h07);
    settle();
    program_registers(8'h00, 8'h00, 8'h00);
    send_byte(8'h11);
    send_byte(8'h22);
    send_byte(8'h33);
    send_byte(rtsp_pkg::DELTA_END);
    settle();

    for (int p = 0; p < RANDOM_SETTINGS; p++) begin
      case (p)
        0: program_registers(8'h00, 8'hFF, 8'h00);
        1: program_registers(8'hFF, 8'h00, 8'hFF);
        3: program_registers(8'h00, 8'h00, 8'h00);
        5: program_registers(8'hFF, 8'hFF, 8'hFF);
        default: program_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   8'($urandom_range(0, 255)));
      endcase
      if (p == 2) holds_asked <= holds_asked + 1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < ITEMS_PER_SETTING) begin
        if ($urandom_range(0, 4) == 0) send_noise();
        else send_table();
      end
      settle();
    end

    $display("run covered %0d stream bytes, checking %0d records and %0d table ends",
             bytes_sent, records_checked, ends_checked);
    $display("over %0d register settings, with one %0d-cycle result hold and a drain after each",
             settings_applied, LONG_HOLD);
    if (mismatches == 0 && outstanding == 0) begin
      $display("relocation_table_stream_parser_top_tb: clean");
    end else begin
      $display("relocation_table_stream_parser_top_tb: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rtsp_pkg.sv
design/rtsp_in_stage.sv
design/rtsp_parser.sv
design/rtsp_out_reg.sv
design/relocation_table_stream_parser_top.sv
design/rtsp_checker.sv
verif/rtsp_result_checker.sv
verif/relocation_table_stream_parser_top_tb.sv
